// ===== design/fipg_pkg.sv =====
// Shared types and constants for the fault-injecting pulse generator.
package fipg_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned DrawW    = 17;
  localparam int unsigned NarrowW  = 16;
  localparam int unsigned PairsW   = 7;
  localparam int unsigned LeftW    = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 8;

  localparam logic [TimeW-1:0]   HalfPeriodRst = 32'd500000;
  localparam logic [NarrowW-1:0] SkipMin       = 16'd2;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_RUN_ENABLE     = 3'd0,
    REG_HALF_PERIOD    = 3'd1,
    REG_BOUNCE_ENABLE  = 3'd2,
    REG_BOUNCE_PAIRS   = 3'd3,
    REG_BOUNCE_WIDTH   = 3'd4,
    REG_DROPOUT_ENABLE = 3'd5,
    REG_SKIP_INTERVAL  = 3'd6,
    REG_JITTER_MAX     = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic               run_enable;
    logic [TimeW-1:0]   half_period_us;
    logic               bounce_enable;
    logic [PairsW-1:0]  bounce_pairs;
    logic [NarrowW-1:0] bounce_width_us;
    logic               dropout_enable;
    logic [NarrowW-1:0] skip_interval;
    logic [NarrowW-1:0] jitter_max_us;
  } cfg_t;

  // State side effects of a register write
  typedef struct packed {
    logic run_stop;
    logic bounce_stop;
    logic phase_clr;
  } clr_t;

  typedef struct packed {
    logic               pulse_level;
    logic               in_bounce;
    logic [LeftW-1:0]   bounce_left;
    logic [TimeW-1:0]   bounce_ref_time;
    logic [TimeW-1:0]   last_toggle_time;
    logic [NarrowW-1:0] dropout_phase;
  } state_t;

  typedef struct packed {
    logic toggle_skipped;
    logic bouncing;
    logic pin_level;
  } result_t;

endpackage

// ===== design/fipg_cfg_regs.sv =====
// Configuration register file and the state clears that writes trigger.
module fipg_cfg_regs
  import fipg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [CfgIdxW-1:0]  idx_i,
  input  logic [CfgDataW-1:0] data_i,
  output cfg_t                cfg_o,
  output clr_t                clr_o
);

  cfg_t cfg_q, cfg_d;
  clr_t clr;

  // Decode a write request
  always_comb begin
    cfg_d = cfg_q;
    clr   = '0;
    if (we_i) begin
      unique case (cfg_reg_e'(idx_i))
        REG_RUN_ENABLE: begin
          cfg_d.run_enable = data_i[0];
          clr.run_stop     = ~data_i[0];
        end
        REG_HALF_PERIOD:   cfg_d.half_period_us = data_i[TimeW-1:0];
        REG_BOUNCE_ENABLE: begin
          cfg_d.bounce_enable = data_i[0];
          clr.bounce_stop     = ~data_i[0];
        end
        REG_BOUNCE_PAIRS:  cfg_d.bounce_pairs = data_i[PairsW-1:0];
        REG_BOUNCE_WIDTH:  cfg_d.bounce_width_us = data_i[NarrowW-1:0];
        REG_DROPOUT_ENABLE: begin
          cfg_d.dropout_enable = data_i[0];
          clr.phase_clr        = 1'b1;
        end
        REG_SKIP_INTERVAL: begin
          cfg_d.skip_interval = data_i[NarrowW-1:0];
          clr.phase_clr       = 1'b1;
        end
        REG_JITTER_MAX:    cfg_d.jitter_max_us = data_i[NarrowW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{run_enable: 1'b0, half_period_us: HalfPeriodRst, bounce_enable: 1'b0,
                 bounce_pairs: '0, bounce_width_us: '0, dropout_enable: 1'b0,
                 skip_interval: SkipMin, jitter_max_us: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
  assign clr_o = clr;

endmodule

// ===== design/fipg_step.sv =====
// Single-pass poll update: jittered period, dropout, bounce and level toggle.
module fipg_step
  import fipg_pkg::*;
(
  input  cfg_t                    cfg_i,
  input  state_t                  state_i,
  input  logic [TimeW-1:0]        now_i,
  input  logic signed [DrawW-1:0] draw_i,
  output state_t                  state_o,
  output result_t                 result_o
);

  logic signed [DrawW:0]   draw_x;
  logic signed [DrawW:0]   lim_x;
  logic signed [DrawW:0]   jit;
  logic signed [TimeW+1:0] period_x;
  logic [TimeW-1:0]        period;
  logic [TimeW-1:0]        since_toggle;
  logic [TimeW-1:0]        since_bounce;
  logic [NarrowW-1:0]      skip_n;
  logic [NarrowW-1:0]      phase_inc;
  logic                    drop;
  logic                    new_level;

  // Jitter clamp and period floor
  always_comb begin
    draw_x = {draw_i[DrawW-1], draw_i};
    lim_x  = $signed({2'b00, cfg_i.jitter_max_us});
    jit    = '0;
    if (cfg_i.jitter_max_us != '0) begin
      if (draw_x > lim_x)       jit = lim_x;
      else if (draw_x < -lim_x) jit = -lim_x;
      else                      jit = draw_x;
    end
    period_x = $signed({2'b00, cfg_i.half_period_us})
             + $signed({{(TimeW+1-DrawW){jit[DrawW]}}, jit});
    if (period_x < $signed((TimeW+2)'(1))) period = TimeW'(1);
    else                                   period = period_x[TimeW-1:0];
  end

  assign since_toggle = now_i - state_i.last_toggle_time;
  assign since_bounce = now_i - state_i.bounce_ref_time;
  assign skip_n       = (cfg_i.skip_interval < SkipMin) ? SkipMin : cfg_i.skip_interval;
  assign phase_inc    = state_i.dropout_phase + NarrowW'(1);
  assign new_level    = ~state_i.pulse_level;

  // State update for one poll
  always_comb begin
    state_o  = state_i;
    drop     = 1'b0;
    result_o = '0;
    if (!cfg_i.run_enable) begin
      state_o.last_toggle_time = now_i;
    end else begin
      if (state_i.in_bounce) begin
        if (since_bounce >= {{(TimeW-NarrowW){1'b0}}, cfg_i.bounce_width_us}) begin
          state_o.pulse_level     = new_level;
          state_o.bounce_ref_time = now_i;
          state_o.bounce_left     = state_i.bounce_left - LeftW'(1);
          if (state_i.bounce_left == LeftW'(1)) state_o.in_bounce = 1'b0;
        end
      end else if (since_toggle >= period) begin
        state_o.last_toggle_time = now_i;
        if (cfg_i.dropout_enable) begin
          if (phase_inc >= skip_n) begin
            drop                  = 1'b1;
            state_o.dropout_phase = '0;
          end else begin
            state_o.dropout_phase = phase_inc;
          end
        end
        if (!drop) begin
          state_o.pulse_level = new_level;
          if (cfg_i.bounce_enable && new_level && cfg_i.bounce_pairs != '0) begin
            state_o.in_bounce       = 1'b1;
            state_o.bounce_left     = {cfg_i.bounce_pairs, 1'b0};
            state_o.bounce_ref_time = now_i;
          end
        end
      end
      result_o.pin_level      = state_o.pulse_level;
      result_o.bouncing       = state_o.in_bounce;
      result_o.toggle_skipped = drop;
    end
  end

endmodule

// ===== design/fault_injecting_pulse_generator_core.sv =====
// Top level of the fault-injecting pulse generator: poll stream in, pin level stream out.
//
// Each poll request (timestamp and signed jitter draw) yields exactly one result request
// with the pin level, a bounce-in-progress flag and a dropped-toggle flag. Polls are taken
// at one per clock unless the output stalls: a poll lands in an input register, then the
// whole state update (jitter clamp, elapsed-time compare, dropout counter, bounce
// sequencer) runs in one pass and loads the result register, and throughput is set
// only by the output side's tready. Configuration writes are always accepted (cfg_ready_o
// is tied high) and take effect on the next cycle; write them only while no poll is in
// flight. Writing run_enable 0 drops the pin low and aborts bounce, writing bounce_enable 0
// aborts bounce, and writing dropout_enable or skip_interval restarts the dropout count.
module fault_injecting_pulse_generator_core
  import fipg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [31:0] now_us, [48:32] jitter_draw, [55:49] zero
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [0] pin_level, [1] bouncing, [2] toggle_skipped, [7:3] zero
  output logic [OutDataW-1:0] m_axis_tdata_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t    cfg;
  clr_t    clr;
  state_t  state_q, state_d, step_state;
  result_t step_res;

  logic                    in_valid_q;
  logic [TimeW-1:0]        in_now_q;
  logic signed [DrawW-1:0] in_draw_q;
  logic                    out_valid_q;
  result_t                 out_res_q;
  logic                    advance;
  logic                    take;

  assign cfg_ready_o = 1'b1;

  fipg_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_valid_i),
    .idx_i  (cfg_index_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg),
    .clr_o  (clr)
  );

  fipg_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .now_i    (in_now_q),
    .draw_i   (in_draw_q),
    .state_o  (step_state),
    .result_o (step_res)
  );

  // Handshake: the input stage moves when the result register is free or being drained
  assign advance         = ~out_valid_q | m_axis_tready_i;
  assign s_axis_tready_o = ~in_valid_q | advance;
  assign take            = s_axis_tvalid_i & s_axis_tready_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_now_q  <= s_axis_tdata_i[TimeW-1:0];
      in_draw_q <= $signed(s_axis_tdata_i[TimeW+DrawW-1:TimeW]);
    end
  end

  // Generator state: register writes first, poll updates otherwise
  always_comb begin
    state_d = state_q;
    if (cfg_valid_i) begin
      if (clr.run_stop) begin
        state_d.pulse_level = 1'b0;
        state_d.in_bounce   = 1'b0;
        state_d.bounce_left = '0;
      end
      if (clr.bounce_stop) begin
        state_d.in_bounce   = 1'b0;
        state_d.bounce_left = '0;
      end
      if (clr.phase_clr) state_d.dropout_phase = '0;
    end else if (in_valid_q && advance) begin
      state_d = step_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q && advance) out_res_q <= step_res;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW-3){1'b0}}, out_res_q.toggle_skipped,
                            out_res_q.bouncing, out_res_q.pin_level};

  // A running bounce always has toggles left to make
  a_bounce_left : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.in_bounce |-> state_q.bounce_left != '0)
    else $error("bounce active with no toggles left");

  // Bounce only exists while generating with bounce enabled
  a_bounce_cfg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.in_bounce |-> (cfg.run_enable && cfg.bounce_enable))
    else $error("bounce active while disabled");

  // Dropout counter stays below the effective interval
  a_phase_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg.dropout_enable |-> (state_q.dropout_phase < cfg.skip_interval ||
                            state_q.dropout_phase < SkipMin))
    else $error("dropout phase out of range");

endmodule
